// ===== design/kefc_pkg.sv =====
package kefc_pkg;

  localparam int unsigned KeyDepth  = 16;
  localparam int unsigned CharDepth = 16;

  localparam int unsigned KeyAw  = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam int unsigned KeyCw  = $clog2(KeyDepth + 1);
  localparam int unsigned CharAw = (CharDepth > 1) ? $clog2(CharDepth) : 1;
  localparam int unsigned CharCw = $clog2(CharDepth + 1);

  localparam int unsigned CodeW   = 8;
  localparam int unsigned EventW  = CodeW + 1;
  localparam int unsigned BmDepth = 256;
  localparam int unsigned BmAw    = 8;

  typedef enum logic [3:0] {
    MODE_KEY_DOWN   = 4'd0,
    MODE_KEY_UP     = 4'd1,
    MODE_CHAR       = 4'd2,
    MODE_READ_KEY   = 4'd3,
    MODE_READ_CHAR  = 4'd4,
    MODE_QUERY      = 4'd5,
    MODE_CLR_KEY    = 4'd6,
    MODE_CLR_CHAR   = 4'd7,
    MODE_CLR_BOTH   = 4'd8,
    MODE_CLR_BITMAP = 4'd9
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic            rd_en;
    logic [BmAw-1:0] rd_addr;
    logic            wr_en;
    logic [BmAw-1:0] wr_addr;
    logic            wr_bit;
    logic            clr;
  } bm_req_t;

endpackage

// ===== design/kefc_ram.sv =====
module kefc_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/kefc_bitmap.sv =====
module kefc_bitmap (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kefc_pkg::bm_req_t req_i,
  output logic             rd_bit_o
);
  import kefc_pkg::*;

  logic [BmDepth-1:0] vld_q;
  logic               rd_vld_q;
  logic [0:0]         rd_data;

  kefc_ram #(
    .Depth(BmDepth),
    .Width(1)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wr_bit),
    .re_i   (req_i.rd_en),
    .raddr_i(req_i.rd_addr),
    .rdata_o(rd_data)
  );

  // entries not written since reset or clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_bit_o = rd_data[0] & rd_vld_q;

endmodule

// ===== design/keyboard_event_fifo_controller_unit.sv =====
// Keyboard event controller: a 256-key pressed bitmap, a key event FIFO and a
// character FIFO, each FIFO 16 deep and dropping its oldest entry when full.
// Input channel: in_valid_i / in_ready_o with mode_i, key_code_i, char_code_i.
// Output channel: out_valid_o / out_ready_i, one result beat for every input
// beat, in order, carrying popped data, the queried key bit and empty flags.
// An input beat is accepted while the unit is idle; acceptance launches the
// synchronous read of the bitmap and FIFO memories, and the execution state
// uses the read data and writes the updated entry and pointers back. The
// result is registered into the output register as execution ends. A new
// item is not accepted until the one in work has left the execution state.
// The output register parts the two sides: a new item is accepted while the
// previous result still waits. If the receiver stalls with a result pending,
// the item in work holds in its write-back cycle until the register frees.
// Reset empties both FIFOs and clears the bitmap valid bits at once, so every
// key reads as released; no clearing pass is needed and the unit is ready in
// the first cycle after reset.
module keyboard_event_fifo_controller_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [3:0]                mode_i,
  input  logic [kefc_pkg::CodeW-1:0] key_code_i,
  input  logic [kefc_pkg::CodeW-1:0] char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      key_event_valid_o,
  output logic                      key_event_is_down_o,
  output logic [kefc_pkg::CodeW-1:0] key_event_code_o,
  output logic                      char_valid_o,
  output logic [kefc_pkg::CodeW-1:0] char_out_o,
  output logic                      key_pressed_o,
  output logic                      key_fifo_empty_o,
  output logic                      char_fifo_empty_o
);
  import kefc_pkg::*;

  localparam int unsigned KeySw  = KeyCw + 1;
  localparam int unsigned CharSw = CharCw + 1;

  state_e state_q, state_d;

  logic [3:0]       mode_q;
  logic [CodeW-1:0] key_q;
  logic [CodeW-1:0] char_q;

  logic [KeyAw-1:0]  k_head_q, k_head_d, k_head_inc, k_tail;
  logic [KeyCw-1:0]  k_cnt_q, k_cnt_d;
  logic [KeySw-1:0]  k_sum;
  logic [CharAw-1:0] c_head_q, c_head_d, c_head_inc, c_tail;
  logic [CharCw-1:0] c_cnt_q, c_cnt_d;
  logic [CharSw-1:0] c_sum;

  logic              k_we;
  logic [KeyAw-1:0]  k_waddr;
  logic [EventW-1:0] k_wdata, k_rdata;
  logic              c_we;
  logic [CharAw-1:0] c_waddr;
  logic [CodeW-1:0]  c_rdata;

  bm_req_t bm_req;
  logic    bm_bit;

  logic in_fire, exec_done;

  logic             r_kv, r_kdown, r_cv, r_press;
  logic [CodeW-1:0] r_kcode, r_char;

  logic             out_valid_q;
  logic             kv_q, kdown_q, cv_q, press_q, kempty_q, cempty_q;
  logic [CodeW-1:0] kcode_q, char_out_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign exec_done  = (state_q == ST_EXEC) & (~out_valid_q | out_ready_i);

  kefc_ram #(
    .Depth(KeyDepth),
    .Width(EventW)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(k_waddr),
    .wdata_i(k_wdata),
    .re_i   (in_fire),
    .raddr_i(k_head_q),
    .rdata_o(k_rdata)
  );

  kefc_ram #(
    .Depth(CharDepth),
    .Width(CodeW)
  ) u_char_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(char_q),
    .re_i   (in_fire),
    .raddr_i(c_head_q),
    .rdata_o(c_rdata)
  );

  kefc_bitmap u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bm_req),
    .rd_bit_o(bm_bit)
  );

  // ring index arithmetic
  always_comb begin
    k_head_inc = (k_head_q == KeyAw'(KeyDepth - 1)) ? '0 : k_head_q + 1'b1;
    k_sum      = KeySw'(k_head_q) + KeySw'(k_cnt_q);
    k_tail     = (k_sum >= KeySw'(KeyDepth)) ? KeyAw'(k_sum - KeySw'(KeyDepth))
                                              : KeyAw'(k_sum);
    c_head_inc = (c_head_q == CharAw'(CharDepth - 1)) ? '0 : c_head_q + 1'b1;
    c_sum      = CharSw'(c_head_q) + CharSw'(c_cnt_q);
    c_tail     = (c_sum >= CharSw'(CharDepth)) ? CharAw'(c_sum - CharSw'(CharDepth))
                                              : CharAw'(c_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      k_head_q <= '0;
      k_cnt_q  <= '0;
      c_head_q <= '0;
      c_cnt_q  <= '0;
    end else begin
      state_q  <= state_d;
      k_head_q <= k_head_d;
      k_cnt_q  <= k_cnt_d;
      c_head_q <= c_head_d;
      c_cnt_q  <= c_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      key_q  <= key_code_i;
      char_q <= char_code_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    k_head_d = k_head_q;
    k_cnt_d  = k_cnt_q;
    c_head_d = c_head_q;
    c_cnt_d  = c_cnt_q;
    k_we     = 1'b0;
    k_waddr  = k_tail;
    k_wdata  = {1'b0, key_q};
    c_we     = 1'b0;
    c_waddr  = c_tail;
    r_kv     = 1'b0;
    r_kdown  = 1'b0;
    r_kcode  = '0;
    r_cv     = 1'b0;
    r_char   = '0;
    r_press  = 1'b0;
    bm_req.rd_en   = in_fire;
    bm_req.rd_addr = key_code_i;
    bm_req.wr_en   = 1'b0;
    bm_req.wr_addr = key_q;
    bm_req.wr_bit  = 1'b0;
    bm_req.clr     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
          case (mode_q)
            MODE_KEY_DOWN, MODE_KEY_UP: begin
              bm_req.wr_en  = 1'b1;
              bm_req.wr_bit = (mode_q == MODE_KEY_DOWN);
              k_we          = 1'b1;
              k_wdata       = {(mode_q == MODE_KEY_DOWN), key_q};
              // full: overwrite the oldest slot and advance the head
              if (k_cnt_q == KeyCw'(KeyDepth)) begin
                k_waddr  = k_head_q;
                k_head_d = k_head_inc;
              end else begin
                k_cnt_d = k_cnt_q + 1'b1;
              end
            end
            MODE_CHAR: begin
              c_we = 1'b1;
              if (c_cnt_q == CharCw'(CharDepth)) begin
                c_waddr  = c_head_q;
                c_head_d = c_head_inc;
              end else begin
                c_cnt_d = c_cnt_q + 1'b1;
              end
            end
            MODE_READ_KEY: begin
              if (k_cnt_q != '0) begin
                r_kv     = 1'b1;
                r_kdown  = k_rdata[CodeW];
                r_kcode  = k_rdata[CodeW-1:0];
                k_head_d = k_head_inc;
                k_cnt_d  = k_cnt_q - 1'b1;
              end
            end
            MODE_READ_CHAR: begin
              if (c_cnt_q != '0) begin
                r_cv     = 1'b1;
                r_char   = c_rdata;
                c_head_d = c_head_inc;
                c_cnt_d  = c_cnt_q - 1'b1;
              end
            end
            MODE_QUERY: begin
              r_press = bm_bit;
            end
            MODE_CLR_KEY: begin
              k_head_d = '0;
              k_cnt_d  = '0;
            end
            MODE_CLR_CHAR: begin
              c_head_d = '0;
              c_cnt_d  = '0;
            end
            MODE_CLR_BOTH: begin
              k_head_d = '0;
              k_cnt_d  = '0;
              c_head_d = '0;
              c_cnt_d  = '0;
            end
            MODE_CLR_BITMAP: begin
              bm_req.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      kv_q       <= r_kv;
      kdown_q    <= r_kdown;
      kcode_q    <= r_kcode;
      cv_q       <= r_cv;
      char_out_q <= r_char;
      press_q    <= r_press;
      kempty_q   <= (k_cnt_d == '0);
      cempty_q   <= (c_cnt_d == '0);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign key_event_valid_o   = kv_q;
  assign key_event_is_down_o = kdown_q;
  assign key_event_code_o    = kcode_q;
  assign char_valid_o        = cv_q;
  assign char_out_o          = char_out_q;
  assign key_pressed_o       = press_q;
  assign key_fifo_empty_o    = kempty_q;
  assign char_fifo_empty_o   = cempty_q;

`ifndef SYNTH
  a_key_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_cnt_q <= KeyCw'(KeyDepth)) && (k_head_q <= KeyAw'(KeyDepth - 1)))
    else $error("key fifo pointers out of range");

  a_char_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_cnt_q <= CharCw'(CharDepth)) && (c_head_q <= CharAw'(CharDepth - 1)))
    else $error("char fifo pointers out of range");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted beat did not enter execution");

  a_exec_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_done |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished item did not reach the output register");

  a_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(kv_q && cv_q))
    else $error("both fifos popped by one item");
`endif

endmodule
